// ===== src/civ_pkg.sv =====
package civ_pkg;

    localparam int SAMPLE_BITS_DEF = 16;
    localparam int COORD_BITS_DEF  = 10;
    localparam int FRAC_BITS_DEF   = 8;
    localparam int ISO_BITS        = 16;
    localparam int NUM_EDGES       = 12;
    localparam int NUM_AXES        = 3;
    localparam int CNT_W           = 4;

    typedef logic [NUM_EDGES-1:0] t_edge_vec;

    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    localparam logic [2:0] EDGE_LO [NUM_EDGES] = '{
        3'd0, 3'd1, 3'd3, 3'd0, 3'd4, 3'd5, 3'd7, 3'd4, 3'd0, 3'd1, 3'd2, 3'd3
    };
    localparam logic [2:0] EDGE_HI [NUM_EDGES] = '{
        3'd1, 3'd2, 3'd2, 3'd3, 3'd5, 3'd6, 3'd6, 3'd7, 3'd4, 3'd5, 3'd6, 3'd7
    };
    localparam logic [1:0] EDGE_AXIS [NUM_EDGES] = '{
        AXIS_X, AXIS_Y, AXIS_X, AXIS_Y, AXIS_X, AXIS_Y, AXIS_X, AXIS_Y,
        AXIS_Z, AXIS_Z, AXIS_Z, AXIS_Z
    };
    // corner offset of the lower end, bit k for axis k
    localparam logic [2:0] EDGE_OFS [NUM_EDGES] = '{
        3'b000, 3'b001, 3'b010, 3'b000, 3'b100, 3'b101, 3'b110, 3'b100,
        3'b000, 3'b001, 3'b011, 3'b010
    };

endpackage

// ===== src/civ_frac_div.sv =====
module civ_frac_div import civ_pkg::*; #(
    parameter int LANES  = NUM_EDGES,
    parameter int NUM_W  = SAMPLE_BITS_DEF + 1,
    parameter int Q_W    = FRAC_BITS_DEF,
    parameter int SIDE_W = 3 * COORD_BITS_DEF + NUM_EDGES
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_vld,
    input  logic [NUM_W-1:0]  i_num [LANES],
    input  logic [NUM_W-1:0]  i_den [LANES],
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_vld,
    output logic [Q_W-1:0]    o_q [LANES],
    output logic [SIDE_W-1:0] o_side
);

    logic              r_vld  [Q_W];
    logic [NUM_W-1:0]  r_rem  [Q_W][LANES];
    logic [NUM_W-1:0]  r_den  [Q_W][LANES];
    logic [Q_W-1:0]    r_q    [Q_W][LANES];
    logic [SIDE_W-1:0] r_side [Q_W];

    for (genvar s = 0; s < Q_W; s++) begin : g_stg
        logic              s_vld;
        logic [NUM_W-1:0]  s_rem [LANES];
        logic [NUM_W-1:0]  s_den [LANES];
        logic [Q_W-1:0]    s_q   [LANES];
        logic [SIDE_W-1:0] s_side;
        logic [NUM_W-1:0]  n_rem [LANES];
        logic [Q_W-1:0]    n_q   [LANES];

        if (s == 0) begin : g_head
            always_comb begin
                s_vld  = i_vld;
                s_side = i_side;
                for (int l = 0; l < LANES; l++) begin
                    s_rem[l] = i_num[l];
                    s_den[l] = i_den[l];
                    s_q[l]   = '0;
                end
            end
        end else begin : g_body
            always_comb begin
                s_vld  = r_vld[s-1];
                s_side = r_side[s-1];
                for (int l = 0; l < LANES; l++) begin
                    s_rem[l] = r_rem[s-1][l];
                    s_den[l] = r_den[s-1][l];
                    s_q[l]   = r_q[s-1][l];
                end
            end
        end

        always_comb begin
            logic [NUM_W:0] t;
            logic           ge;
            for (int l = 0; l < LANES; l++) begin
                t        = {s_rem[l], 1'b0};
                ge       = (t >= {1'b0, s_den[l]});
                n_rem[l] = ge ? NUM_W'(t - {1'b0, s_den[l]}) : NUM_W'(t);
                n_q[l]   = {s_q[l][Q_W-2:0], ge};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else if (i_en) begin
                r_vld[s] <= s_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_side[s] <= s_side;
                for (int l = 0; l < LANES; l++) begin
                    r_rem[s][l] <= n_rem[l];
                    r_den[s][l] <= s_den[l];
                    r_q[s][l]   <= n_q[l];
                end
            end
        end
    end

    assign o_vld  = r_vld[Q_W-1];
    assign o_side = r_side[Q_W-1];
    assign o_q    = r_q[Q_W-1];

endmodule

// ===== src/civ_cnt_div.sv =====
module civ_cnt_div import civ_pkg::*; #(
    parameter int LANES = NUM_AXES,
    parameter int DIV_W = COORD_BITS_DEF + FRAC_BITS_DEF + 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_vld,
    input  logic [DIV_W-1:0] i_dvd [LANES],
    input  logic [CNT_W-1:0] i_cnt,
    output logic             o_vld,
    output logic [DIV_W-1:0] o_quo [LANES],
    output logic [CNT_W-1:0] o_cnt
);

    localparam int ACC_W = CNT_W + DIV_W;

    logic             r_vld [DIV_W];
    logic [ACC_W-1:0] r_acc [DIV_W][LANES];
    logic [CNT_W-1:0] r_cnt [DIV_W];

    for (genvar s = 0; s < DIV_W; s++) begin : g_stg
        logic             s_vld;
        logic [ACC_W-1:0] s_acc [LANES];
        logic [CNT_W-1:0] s_cnt;
        logic [ACC_W-1:0] n_acc [LANES];

        if (s == 0) begin : g_head
            always_comb begin
                s_vld = i_vld;
                s_cnt = i_cnt;
                for (int l = 0; l < LANES; l++) begin
                    s_acc[l] = {{CNT_W{1'b0}}, i_dvd[l]};
                end
            end
        end else begin : g_body
            always_comb begin
                s_vld = r_vld[s-1];
                s_cnt = r_cnt[s-1];
                for (int l = 0; l < LANES; l++) begin
                    s_acc[l] = r_acc[s-1][l];
                end
            end
        end

        always_comb begin
            logic [ACC_W:0]   sh;
            logic [CNT_W:0]   t;
            logic [CNT_W:0]   hi;
            logic             ge;
            for (int l = 0; l < LANES; l++) begin
                sh       = {s_acc[l], 1'b0};
                t        = sh[ACC_W:DIV_W];
                ge       = (t >= {1'b0, s_cnt});
                hi       = ge ? (t - {1'b0, s_cnt}) : t;
                n_acc[l] = {hi[CNT_W-1:0], sh[DIV_W-1:1], ge};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else if (i_en) begin
                r_vld[s] <= s_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_cnt[s] <= s_cnt;
                for (int l = 0; l < LANES; l++) begin
                    r_acc[s][l] <= n_acc[l];
                end
            end
        end
    end

    assign o_vld = r_vld[DIV_W-1];
    assign o_cnt = r_cnt[DIV_W-1];

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            o_quo[l] = r_acc[DIV_W-1][l][DIV_W-1:0];
        end
    end

endmodule

// ===== src/cube_isosurface_vertex_unit.sv =====
// Channel  | Valid / ready               | Payload
// config   | i_cfg_valid / o_cfg_ready   | i_iso_level
// cube in  | i_in_valid / o_in_ready     | i_origin_x/y/z, i_sample_0..7
// vertex   | o_out_valid / i_out_ready   | o_vertex_valid, o_crossing_count, o_vertex_x/y/z
//
// One cube per cycle while the output is not held; the edge divider and the centroid divider
// each resolve one quotient bit per stage.
// Synchronous active-low reset clears all valid bits and sets the isovalue to zero.
// A held output stalls every stage at once; nothing is dropped or repeated.
module cube_isosurface_vertex_unit import civ_pkg::*; #(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int COORD_BITS  = COORD_BITS_DEF,
    parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [ISO_BITS-1:0]                  i_iso_level,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic [COORD_BITS-1:0]                i_origin_x,
    input  logic [COORD_BITS-1:0]                i_origin_y,
    input  logic [COORD_BITS-1:0]                i_origin_z,
    input  logic signed [SAMPLE_BITS-1:0]        i_sample_0,
    input  logic signed [SAMPLE_BITS-1:0]        i_sample_1,
    input  logic signed [SAMPLE_BITS-1:0]        i_sample_2,
    input  logic signed [SAMPLE_BITS-1:0]        i_sample_3,
    input  logic signed [SAMPLE_BITS-1:0]        i_sample_4,
    input  logic signed [SAMPLE_BITS-1:0]        i_sample_5,
    input  logic signed [SAMPLE_BITS-1:0]        i_sample_6,
    input  logic signed [SAMPLE_BITS-1:0]        i_sample_7,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic                                 o_vertex_valid,
    output logic [CNT_W-1:0]                     o_crossing_count,
    output logic [COORD_BITS+FRAC_BITS:0]        o_vertex_x,
    output logic [COORD_BITS+FRAC_BITS:0]        o_vertex_y,
    output logic [COORD_BITS+FRAC_BITS:0]        o_vertex_z
);

    localparam int MAG_W  = SAMPLE_BITS + 1;
    localparam int SIDE_W = NUM_AXES * COORD_BITS + NUM_EDGES;
    localparam int FS_W   = FRAC_BITS + 2;
    localparam int POS_W  = COORD_BITS + FRAC_BITS + 1;
    localparam int SUM_W  = COORD_BITS + FRAC_BITS + 4;
    localparam int MUL_W  = COORD_BITS + CNT_W;

    logic en;
    assign en          = !o_out_valid || i_out_ready;
    assign o_in_ready  = en;
    assign o_cfg_ready = 1'b1;

    logic [ISO_BITS-1:0] r_iso;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iso <= '0;
        end else if (i_cfg_valid) begin
            r_iso <= i_iso_level;
        end
    end

    // edge classification and interpolation operands
    logic signed [SAMPLE_BITS-1:0] iso_s;
    logic signed [SAMPLE_BITS-1:0] smp [8];
    logic [MAG_W-1:0] n_num [NUM_EDGES];
    logic [MAG_W-1:0] n_den [NUM_EDGES];
    t_edge_vec        n_cross;

    assign iso_s  = $signed(SAMPLE_BITS'(r_iso));
    assign smp[0] = i_sample_0;
    assign smp[1] = i_sample_1;
    assign smp[2] = i_sample_2;
    assign smp[3] = i_sample_3;
    assign smp[4] = i_sample_4;
    assign smp[5] = i_sample_5;
    assign smp[6] = i_sample_6;
    assign smp[7] = i_sample_7;

    always_comb begin
        logic signed [MAG_W:0] lo;
        logic signed [MAG_W:0] hi;
        logic signed [MAG_W:0] c;
        logic signed [MAG_W:0] dn;
        logic signed [MAG_W:0] dd;
        c = (MAG_W+1)'(iso_s);
        for (int e = 0; e < NUM_EDGES; e++) begin
            lo         = (MAG_W+1)'(smp[EDGE_LO[e]]);
            hi         = (MAG_W+1)'(smp[EDGE_HI[e]]);
            dn         = c - lo;
            dd         = hi - lo;
            n_num[e]   = MAG_W'((dn < 0) ? -dn : dn);
            n_den[e]   = MAG_W'((dd < 0) ? -dd : dd);
            n_cross[e] = ((lo < c) && (hi > c)) || ((lo > c) && (hi < c));
        end
    end

    logic              r_s0_vld;
    logic [MAG_W-1:0]  r_s0_num [NUM_EDGES];
    logic [MAG_W-1:0]  r_s0_den [NUM_EDGES];
    logic [SIDE_W-1:0] r_s0_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_vld <= 1'b0;
        end else if (en) begin
            r_s0_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s0_num  <= n_num;
            r_s0_den  <= n_den;
            r_s0_side <= {n_cross, i_origin_z, i_origin_y, i_origin_x};
        end
    end

    logic              fd_vld;
    logic [FRAC_BITS-1:0] fd_q [NUM_EDGES];
    logic [SIDE_W-1:0] fd_side;

    civ_frac_div #(
        .LANES  (NUM_EDGES),
        .NUM_W  (MAG_W),
        .Q_W    (FRAC_BITS),
        .SIDE_W (SIDE_W)
    ) u_frac_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (r_s0_vld),
        .i_num   (r_s0_num),
        .i_den   (r_s0_den),
        .i_side  (r_s0_side),
        .o_vld   (fd_vld),
        .o_q     (fd_q),
        .o_side  (fd_side)
    );

    // per-axis partial sums
    t_edge_vec        fd_cross;
    logic [CNT_W-1:0] n_cnt;
    logic [FS_W-1:0]  n_fs  [NUM_AXES];
    logic [CNT_W-1:0] n_one [NUM_AXES];

    assign fd_cross = fd_side[SIDE_W-1 -: NUM_EDGES];

    always_comb begin
        n_cnt = '0;
        for (int k = 0; k < NUM_AXES; k++) begin
            n_fs[k]  = '0;
            n_one[k] = '0;
        end
        for (int e = 0; e < NUM_EDGES; e++) begin
            if (fd_cross[e]) begin
                n_cnt = n_cnt + CNT_W'(1);
                for (int k = 0; k < NUM_AXES; k++) begin
                    if (EDGE_AXIS[e] == 2'(k)) begin
                        n_fs[k] = n_fs[k] + FS_W'(fd_q[e]);
                    end else if (EDGE_OFS[e][k]) begin
                        n_one[k] = n_one[k] + CNT_W'(1);
                    end
                end
            end
        end
    end

    logic                  r_a_vld;
    logic [CNT_W-1:0]      r_a_cnt;
    logic [FS_W-1:0]       r_a_fs  [NUM_AXES];
    logic [CNT_W-1:0]      r_a_one [NUM_AXES];
    logic [COORD_BITS-1:0] r_a_org [NUM_AXES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else if (en) begin
            r_a_vld <= fd_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_cnt <= n_cnt;
            r_a_fs  <= n_fs;
            r_a_one <= n_one;
            for (int k = 0; k < NUM_AXES; k++) begin
                r_a_org[k] <= fd_side[k*COORD_BITS +: COORD_BITS];
            end
        end
    end

    // full sums: (count * origin + ones) * 2^F + fraction sum
    logic [SUM_W-1:0] n_sum [NUM_AXES];

    always_comb begin
        for (int k = 0; k < NUM_AXES; k++) begin
            n_sum[k] = (SUM_W'(MUL_W'(r_a_cnt) * MUL_W'(r_a_org[k]) + MUL_W'(r_a_one[k]))
                        << FRAC_BITS) + SUM_W'(r_a_fs[k]);
        end
    end

    logic             r_b_vld;
    logic [CNT_W-1:0] r_b_cnt;
    logic [SUM_W-1:0] r_b_sum [NUM_AXES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
        end else if (en) begin
            r_b_vld <= r_a_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_b_cnt <= r_a_cnt;
            r_b_sum <= n_sum;
        end
    end

    logic             cd_vld;
    logic [SUM_W-1:0] cd_quo [NUM_AXES];
    logic [CNT_W-1:0] cd_cnt;

    civ_cnt_div #(
        .LANES (NUM_AXES),
        .DIV_W (SUM_W)
    ) u_cnt_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (r_b_vld),
        .i_dvd   (r_b_sum),
        .i_cnt   (r_b_cnt),
        .o_vld   (cd_vld),
        .o_quo   (cd_quo),
        .o_cnt   (cd_cnt)
    );

    logic             n_hit;
    logic [POS_W-1:0] n_pos [NUM_AXES];

    assign n_hit = (cd_cnt != '0);

    always_comb begin
        for (int k = 0; k < NUM_AXES; k++) begin
            n_pos[k] = n_hit ? cd_quo[k][POS_W-1:0] : '0;
        end
    end

    logic             r_out_vld;
    logic             r_out_hit;
    logic [CNT_W-1:0] r_out_cnt;
    logic [POS_W-1:0] r_out_pos [NUM_AXES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_out_vld <= cd_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_hit <= n_hit;
            r_out_cnt <= cd_cnt;
            r_out_pos <= n_pos;
        end
    end

    assign o_out_valid      = r_out_vld;
    assign o_vertex_valid   = r_out_hit;
    assign o_crossing_count = r_out_cnt;
    assign o_vertex_x       = r_out_pos[0];
    assign o_vertex_y       = r_out_pos[1];
    assign o_vertex_z       = r_out_pos[2];

    a_rst_clear: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    a_hit_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_vertex_valid == (o_crossing_count != '0)))
        else $error("vertex flag disagrees with crossing count");

    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_crossing_count <= CNT_W'(NUM_EDGES)))
        else $error("crossing count above edge count");

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_vertex_valid) |->
        (o_vertex_x == '0 && o_vertex_y == '0 && o_vertex_z == '0))
        else $error("position not zero without crossings");

endmodule
